// File: sv/single_wire_uart_datagram_framer_top_defines.svh
// Assertion macros shared by the single-wire UART datagram framer modules.
// No dependencies; included by the modules that carry assertions.
`ifndef SINGLE_WIRE_UART_DATAGRAM_FRAMER_TOP_DEFINES_SVH
`define SINGLE_WIRE_UART_DATAGRAM_FRAMER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SWUDF_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("swudf assertion failed");
// Checked on every clock edge, reset included.
`define SWUDF_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("swudf assertion failed");
`else
`define SWUDF_ASSERT(name, prop)
`define SWUDF_ASSERT_ALWAYS(name, prop)
`endif
`endif

// File: sv/swudf_pkg.sv
// Shared types, codes and the CRC-8 step for the datagram framer.
// No dependencies.
package swudf_pkg;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RX    = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_FLAG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_FLAG = 2'd2;

    localparam logic [7:0] SYNC_RESET       = 8'h05;
    localparam logic [7:0] READ_FLAG_RESET  = 8'h00;
    localparam logic [7:0] WRITE_FLAG_RESET = 8'h80;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [3:0] READ_ECHO_BYTES  = 4'd4;
    localparam logic [3:0] WRITE_ECHO_BYTES = 4'd8;

    localparam logic [2:0] REPLY_DATA_FIRST = 3'd3;
    localparam logic [2:0] REPLY_CRC_IDX    = 3'd7;

    localparam logic [2:0] READ_LAST_IDX  = 3'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  addr;
        logic [7:0]  reg_byte;
        logic [31:0] data;
        logic        status;
    } cmd_t;

    // One data byte into the CRC, LSB first, register shifting left.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7] ^ b[k])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: sv/swudf_fifo.sv
// Short command queue between the framer front and the serialiser.
// Depends on swudf_pkg and the assertion macro header.
`include "single_wire_uart_datagram_framer_top_defines.svh"
module swudf_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  swudf_pkg::cmd_t  push_cmd,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output swudf_pkg::cmd_t  head
);

    swudf_pkg::cmd_t entry_reg [swudf_pkg::QUEUE_DEPTH];

    logic [swudf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [swudf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [swudf_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    localparam logic [swudf_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        swudf_pkg::QUEUE_PTR_W'(swudf_pkg::QUEUE_DEPTH - 1);
    localparam logic [swudf_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        swudf_pkg::QUEUE_CNT_W'(swudf_pkg::QUEUE_DEPTH);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `SWUDF_ASSERT(a_no_overflow, push |-> !full)
    `SWUDF_ASSERT(a_no_underflow, pop |-> !empty)

endmodule

// File: sv/swudf_front.sv
// Front of the framer: accepts input beats, tracks echo and reply phases,
// checks the reply CRC and queues commands. Depends on swudf_pkg and the macro header.
`include "single_wire_uart_datagram_framer_top_defines.svh"
module swudf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        s_tuser,  // action
    // slave_address, register_address, write_data, rx_byte
    input  logic [swudf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [7:0]                        read_flag,
    input  logic [7:0]                        write_flag,
    input  logic                              queue_full,
    output logic                              push,
    output swudf_pkg::cmd_t                   push_cmd
);

    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_ECHO_READ  = 2'd1;
    localparam logic [1:0] PH_ECHO_WRITE = 2'd2;
    localparam logic [1:0] PH_REPLY      = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  echo_reg, echo_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] shift_reg, shift_next;

    logic        accept;
    logic [7:0]  slave_address;
    logic [6:0]  register_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;

    assign slave_address    = s_tdata[7:0];
    assign register_address = s_tdata[14:8];
    assign write_data       = s_tdata[46:15];
    assign rx_byte          = s_tdata[54:47];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        echo_next  = echo_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        shift_next = shift_reg;
        push       = 1'b0;
        push_cmd.op       = swudf_pkg::CMD_READ;
        push_cmd.addr     = slave_address;
        push_cmd.reg_byte = {1'b0, register_address} | read_flag;
        push_cmd.data     = write_data;
        push_cmd.status   = 1'b0;
        if (accept)
        begin
            case (s_tuser)
                swudf_pkg::ACT_READ:
                begin
                    // a new request abandons whatever is in progress
                    push       = 1'b1;
                    phase_next = PH_ECHO_READ;
                    echo_next  = swudf_pkg::READ_ECHO_BYTES;
                    count_next = '0;
                    crc_next   = '0;
                    shift_next = '0;
                end
                swudf_pkg::ACT_WRITE:
                begin
                    push              = 1'b1;
                    push_cmd.op       = swudf_pkg::CMD_WRITE;
                    push_cmd.reg_byte = {1'b0, register_address} | write_flag;
                    phase_next        = PH_ECHO_WRITE;
                    echo_next         = swudf_pkg::WRITE_ECHO_BYTES;
                    count_next        = '0;
                    crc_next          = '0;
                    shift_next        = '0;
                end
                swudf_pkg::ACT_RX:
                begin
                    if (phase_reg inside {PH_ECHO_READ, PH_ECHO_WRITE})
                    begin
                        echo_next = echo_reg - 1'b1;
                        if (echo_reg == 4'd1)
                        begin
                            phase_next = (phase_reg == PH_ECHO_READ) ? PH_REPLY : PH_IDLE;
                            count_next = '0;
                            crc_next   = '0;
                            shift_next = '0;
                        end
                    end
                    else if (phase_reg == PH_REPLY)
                    begin
                        if (count_reg != swudf_pkg::REPLY_CRC_IDX)
                        begin
                            crc_next = swudf_pkg::crc8_feed(crc_reg, rx_byte);
                            if (count_reg >= swudf_pkg::REPLY_DATA_FIRST)
                                shift_next = {shift_reg[23:0], rx_byte};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            push            = 1'b1;
                            push_cmd.op     = swudf_pkg::CMD_REPLY;
                            push_cmd.data   = shift_reg;
                            push_cmd.status = (crc_reg != rx_byte);
                            phase_next      = PH_IDLE;
                            echo_next       = '0;
                            count_next      = '0;
                            crc_next        = '0;
                            shift_next      = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            echo_reg  <= '0;
            count_reg <= '0;
            crc_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            echo_reg  <= echo_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            shift_reg <= shift_next;
        end
    end

    `SWUDF_ASSERT_ALWAYS(a_echo_pending,
        (phase_reg == PH_ECHO_READ || phase_reg == PH_ECHO_WRITE) |-> echo_reg != 4'd0)
    `SWUDF_ASSERT_ALWAYS(a_count_in_reply, (count_reg != 3'd0) |-> phase_reg == PH_REPLY)

endmodule

// File: sv/swudf_back.sv
// Back of the framer: expands queued commands into transmit beats with the
// request CRC, or a single reply beat. Depends on swudf_pkg and the macro header.
`include "single_wire_uart_datagram_framer_top_defines.svh"
module swudf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        sync_byte,
    input  logic                              q_empty,
    input  swudf_pkg::cmd_t                   q_head,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tx_byte, status, read_data
    output logic [swudf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser   // kind
);

    logic            busy_reg, busy_next;
    swudf_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]      idx_reg, idx_next;
    logic [7:0]      crc_reg, crc_next;
    logic            out_valid_reg, out_valid_next;

    logic            kind_reg, kind_next;
    logic [7:0]      byte_reg, byte_next;
    logic            last_reg, last_next;
    logic            status_reg, status_next;
    logic [31:0]     data_reg, data_next;

    swudf_pkg::cmd_t src;
    logic [2:0]      idx_cur;
    logic [7:0]      crc_cur;
    logic [7:0]      tx;
    logic            last_byte;
    logic            advance;
    logic            have;
    logic            fire;

    assign src     = busy_reg ? cmd_reg : q_head;
    assign idx_cur = busy_reg ? idx_reg : 3'd0;
    assign crc_cur = busy_reg ? crc_reg : 8'd0;
    assign advance = !out_valid_reg || m_tready;
    assign have    = busy_reg || !q_empty;
    assign fire    = advance && have;
    assign q_pop   = fire && !busy_reg;

    always_comb
    begin
        case (idx_cur)
            3'd0: tx = sync_byte;
            3'd1: tx = src.addr;
            3'd2: tx = src.reg_byte;
            3'd3: tx = (src.op == swudf_pkg::CMD_WRITE) ? src.data[31:24] : crc_cur;
            3'd4: tx = src.data[23:16];
            3'd5: tx = src.data[15:8];
            3'd6: tx = src.data[7:0];
            default: tx = crc_cur;
        endcase
        last_byte = (src.op == swudf_pkg::CMD_READ && idx_cur == swudf_pkg::READ_LAST_IDX) ||
                    (src.op == swudf_pkg::CMD_WRITE && idx_cur == swudf_pkg::WRITE_LAST_IDX);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = advance ? have : out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        if (fire)
        begin
            if (src.op == swudf_pkg::CMD_REPLY)
            begin
                kind_next   = 1'b1;
                byte_next   = '0;
                last_next   = 1'b0;
                status_next = src.status;
                data_next   = src.data;
                busy_next   = 1'b0;
            end
            else
            begin
                kind_next   = 1'b0;
                byte_next   = tx;
                last_next   = last_byte;
                status_next = 1'b0;
                data_next   = '0;
                busy_next   = !last_byte;
                cmd_next    = src;
                idx_next    = idx_cur + 1'b1;
                crc_next    = swudf_pkg::crc8_feed(crc_cur, tx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, data_reg, status_reg, byte_reg};

    `SWUDF_ASSERT(a_busy_mid_frame, busy_reg |-> idx_reg != 3'd0)
    `SWUDF_ASSERT(a_busy_not_reply, busy_reg |-> cmd_reg.op != swudf_pkg::CMD_REPLY)

endmodule

// File: sv/single_wire_uart_datagram_framer_top.sv
// Path: an accepted request beat is written into the command queue, and the back
// serialiser then registers the first result beat from the queue head.
// Throughput: one output beat per cycle while m_tready is high; a read gives 4 beats,
// a write 8, a completed reply 1; the back serialiser's one byte per cycle sets this.
// Input beats are taken every cycle while the two-entry command queue has room.
// Reset (rst_n, asynchronous, active low) clears all phase, CRC and queue state and
// restores sync_byte 0x05, read_flag 0x00, write_flag 0x80.
module single_wire_uart_datagram_framer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swudf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // bits 7:0 slave_address, 14:8 register_address, 46:15 write_data,
    // 54:47 rx_byte, 55 zero
    input  logic [swudf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                        s_tuser,  // bits 1:0 action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bits 7:0 tx_byte, 8 status, 40:9 read_data, 47:41 zero
    output logic [swudf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,  // last
    output logic                              m_tuser   // bit 0 kind
);

    logic [7:0] sync_reg;
    logic [7:0] read_flag_reg;
    logic [7:0] write_flag_reg;

    logic            push;
    swudf_pkg::cmd_t push_cmd;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    swudf_pkg::cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg       <= swudf_pkg::SYNC_RESET;
            read_flag_reg  <= swudf_pkg::READ_FLAG_RESET;
            write_flag_reg <= swudf_pkg::WRITE_FLAG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swudf_pkg::CFG_SYNC:       sync_reg       <= cfg_data;
                swudf_pkg::CFG_READ_FLAG:  read_flag_reg  <= cfg_data;
                swudf_pkg::CFG_WRITE_FLAG: write_flag_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    swudf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .read_flag  (read_flag_reg),
        .write_flag (write_flag_reg),
        .queue_full (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    swudf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    swudf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_byte (sync_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
